### hdl/fqpl_pkg.sv
// shared constants, codes and control structs for the fifo queue with peek and listing
package fqpl_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
    logic emit;
    logic list_emit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            out_free;
    logic            list_last;
  } stat_t;

endpackage

### hdl/fqpl_if.sv
// request and response channel interfaces
interface fqpl_req_if;
  logic                             valid;
  logic                             ready;
  logic [fqpl_pkg::OP_W-1:0]        operation;
  logic signed [fqpl_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface fqpl_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fqpl_pkg::DATA_W-1:0]   result_value;
  logic [fqpl_pkg::STATUS_W-1:0]        status;
  logic [fqpl_pkg::COUNT_W-1:0]         entry_count;
  logic                                 queue_empty;
  logic signed [fqpl_pkg::DATA_W-1:0]   front_value;
  logic signed [fqpl_pkg::DATA_W-1:0]   rear_value;
  logic                                 last;

  modport source (output valid, output result_value, output status, output entry_count,
                  output queue_empty, output front_value, output rear_value, output last,
                  input ready);
  modport sink (input valid, input result_value, input status, input entry_count,
                input queue_empty, input front_value, input rear_value, input last,
                output ready);
endinterface

### hdl/fifo_queue_with_peek_and_listing_core.sv
// top level of the fifo queue with peek and listing
//
// req carries one operation per word: enqueue value, dequeue front, or list all
// entries front to rear; operation code 3 is taken and dropped with no result.
// rsp carries one word per result with a snapshot of count, empty flag, front and
// rear after the operation; last marks the final word of a request.
// a request passes the execute and then the emit state before its result is valid,
// and a dequeue that finds entries also passes a fetch state between them to load the
// new front read from the store; a listing goes from execute to the list state, and
// its n entries give n words, one word per cycle while the receiver takes them,
// paced by the store read port.
// one request is worked at a time; req.ready is high only while the sequencer idles.
// the output register holds a word until rsp.ready; a stalled receiver stalls the
// sequencer, and no word is dropped or repeated.
// synchronous reset empties the queue and clears the output valid flag; the store
// contents are not cleared and no clearing pass is needed.
module fifo_queue_with_peek_and_listing_core #(
  parameter int DEPTH = fqpl_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  fqpl_req_if.sink   req,
  fqpl_rsp_if.source rsp
);

  fqpl_pkg::cmd_t  cmd;
  fqpl_pkg::stat_t stat;
  logic            ready;

  assign req.ready = ready;

  fqpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .stat      (stat),
    .cmd       (cmd),
    .req_ready (ready)
  );

  fqpl_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .operation (req.operation),
    .value     (req.value),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation != fqpl_pkg::OP_NONE) |=> !req.ready)
    else $error("request accepted while an earlier request still in progress");

  a_empty_snapshot: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.queue_empty) |->
      (rsp.entry_count == '0 && rsp.front_value == '0 && rsp.rear_value == '0))
    else $error("empty snapshot carries nonzero count or values");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != fqpl_pkg::ST_OK) |-> (rsp.last && rsp.result_value == '0))
    else $error("error result not a single zero word");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> !req.ready)
    else $error("sequencer idle in the middle of a listing");
`endif

endmodule

### hdl/fqpl_datapath.sv
// queue storage, pointers, front and rear registers and the output register
module fqpl_datapath #(
  parameter int DEPTH = fqpl_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [fqpl_pkg::OP_W-1:0]          operation,
  input  logic signed [fqpl_pkg::DATA_W-1:0] value,
  input  fqpl_pkg::cmd_t                     cmd,
  output fqpl_pkg::stat_t                    stat,
  fqpl_rsp_if.source                         rsp
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [fqpl_pkg::DATA_W-1:0]   mem [DEPTH];
  logic [fqpl_pkg::DATA_W-1:0]   rdata;
  logic [PTR_W-1:0]              rd_ptr;
  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              list_ptr;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              remaining;
  logic [fqpl_pkg::OP_W-1:0]     op;
  logic [fqpl_pkg::DATA_W-1:0]   val;
  logic [fqpl_pkg::DATA_W-1:0]   front;
  logic [fqpl_pkg::DATA_W-1:0]   rear;
  logic [fqpl_pkg::DATA_W-1:0]   res_value;
  logic [fqpl_pkg::STATUS_W-1:0] res_status;
  logic                          out_valid;

  logic             empty;
  logic             full;
  logic             out_free;
  logic             wr_en;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] rd_ptr_adv;
  logic [PTR_W-1:0] list_ptr_adv;

  assign empty        = (count == '0);
  assign full         = (count == CNT_FULL);
  assign out_free     = !out_valid || rsp.ready;
  assign rd_ptr_adv   = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign list_ptr_adv = (list_ptr == PTR_LAST) ? '0 : list_ptr + 1'b1;

  assign stat.op        = op;
  assign stat.empty     = empty;
  assign stat.out_free  = out_free;
  assign stat.list_last = (remaining == CNT_W'(1));

  assign wr_en = cmd.exec && (op == fqpl_pkg::OP_ENQ) && !full;
  assign rd_en = (cmd.exec && (op != fqpl_pkg::OP_ENQ)) || cmd.list_emit;

  always_comb begin
    rd_addr = list_ptr;
    if (cmd.exec) begin
      rd_addr = (op == fqpl_pkg::OP_DEQ) ? rd_ptr_adv : rd_ptr;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= val;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else if (cmd.exec) begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
        count  <= count + 1'b1;
      end else if (op == fqpl_pkg::OP_DEQ && !empty) begin
        rd_ptr <= rd_ptr_adv;
        count  <= count - 1'b1;
      end
    end
  end

  // item, result and list registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= operation;
      val <= value;
    end
    if (cmd.exec) begin
      res_value  <= '0;
      res_status <= fqpl_pkg::ST_OK;
      case (op)
        fqpl_pkg::OP_ENQ: begin
          if (full) begin
            res_status <= fqpl_pkg::ST_FULL;
          end else begin
            rear <= val;
            if (empty) begin
              front <= val;
            end
          end
        end
        fqpl_pkg::OP_DEQ: begin
          if (empty) begin
            res_status <= fqpl_pkg::ST_EMPTY;
          end else begin
            res_value <= front;
          end
        end
        fqpl_pkg::OP_LIST: begin
          if (empty) begin
            res_status <= fqpl_pkg::ST_EMPTY;
          end else begin
            list_ptr  <= rd_ptr_adv;
            remaining <= count;
          end
        end
        default: begin
          res_status <= fqpl_pkg::ST_OK;
        end
      endcase
    end
    if (cmd.fetch) begin
      front <= rdata;
    end
    if (cmd.list_emit) begin
      list_ptr  <= list_ptr_adv;
      remaining <= remaining - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.list_emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.list_emit) begin
      rsp.result_value <= cmd.list_emit ? rdata : res_value;
      rsp.status       <= cmd.list_emit ? fqpl_pkg::ST_OK : res_status;
      rsp.entry_count  <= fqpl_pkg::COUNT_W'(count);
      rsp.queue_empty  <= empty;
      rsp.front_value  <= empty ? '0 : front;
      rsp.rear_value   <= empty ? '0 : rear;
      rsp.last         <= cmd.list_emit ? stat.list_last : 1'b1;
    end
  end

  assign rsp.valid = out_valid;

endmodule

### hdl/fqpl_ctrl.sv
// sequencer that steps each request through the execute, fetch, emit and list states its operation needs
module fqpl_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [fqpl_pkg::OP_W-1:0] req_op,
  input  fqpl_pkg::stat_t           stat,
  output fqpl_pkg::cmd_t            cmd,
  output logic                      req_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_LIST  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          if (req_op != fqpl_pkg::OP_NONE) begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.empty) begin
          state_next = S_EMIT;
        end else if (stat.op == fqpl_pkg::OP_DEQ) begin
          state_next = S_FETCH;
        end else if (stat.op == fqpl_pkg::OP_LIST) begin
          state_next = S_LIST;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.list_emit = 1'b1;
          if (stat.list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### verif/fifo_queue_with_peek_and_listing_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the fifo queue with enqueue, dequeue and listing
module fifo_queue_with_peek_and_listing_core_tb;

  localparam int DEPTH       = fqpl_pkg::DEPTH_DEFAULT;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [fqpl_pkg::OP_W-1:0]          operation;
    logic signed [fqpl_pkg::DATA_W-1:0] value;
    int                                 phase;
    bit                                 drain;
    bit                                 hold;
  } op_item_t;

  typedef struct packed {
    logic signed [fqpl_pkg::DATA_W-1:0] result_value;
    logic [fqpl_pkg::STATUS_W-1:0]      status;
    logic [fqpl_pkg::COUNT_W-1:0]       entry_count;
    logic                               queue_empty;
    logic signed [fqpl_pkg::DATA_W-1:0] front_value;
    logic signed [fqpl_pkg::DATA_W-1:0] rear_value;
    logic                               last;
  } snapshot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fqpl_req_if req_ch ();
  fqpl_rsp_if rsp_ch ();

  fifo_queue_with_peek_and_listing_core #(.DEPTH(DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  op_item_t                           op_backlog[$];
  logic signed [fqpl_pkg::DATA_W-1:0] held_values[$];
  snapshot_t                          due_words[$];
  op_item_t                           offered;
  int                                 items_total;
  int                                 items_taken;
  int                                 mismatches;
  int                                 send_phase;
  int                                 hold_requests;
  int                                 holds_seen;
  int                                 hold_left;
  int                                 quiet_cycles;
  int                                 gen_count;
  bit                                 gen_filling;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int sender_idle_pct(int ph);
    return (ph == 1) ? 48 : (ph == 3) ? 16 : 0;
  endfunction

  function automatic int receiver_stall_pct(int ph);
    return (ph == 2) ? 48 : (ph == 3) ? 16 : 0;
  endfunction

  function automatic void push_snapshot(logic signed [fqpl_pkg::DATA_W-1:0] val,
                                        logic [fqpl_pkg::STATUS_W-1:0] st, logic fin);
    snapshot_t s;
    s.result_value = val;
    s.status       = st;
    s.entry_count  = fqpl_pkg::COUNT_W'(held_values.size());
    s.queue_empty  = (held_values.size() == 0);
    s.front_value  = s.queue_empty ? '0 : held_values[0];
    s.rear_value   = s.queue_empty ? '0 : held_values[$];
    s.last         = fin;
    due_words.push_back(s);
  endfunction

  function automatic void apply_op(op_item_t it);
    logic signed [fqpl_pkg::DATA_W-1:0] got;
    int n;
    n = held_values.size();
    case (it.operation)
      fqpl_pkg::OP_ENQ: begin
        if (n >= DEPTH) begin
          push_snapshot('0, fqpl_pkg::ST_FULL, 1'b1);
        end else begin
          held_values.push_back(it.value);
          push_snapshot('0, fqpl_pkg::ST_OK, 1'b1);
        end
      end
      fqpl_pkg::OP_DEQ: begin
        if (n == 0) begin
          push_snapshot('0, fqpl_pkg::ST_EMPTY, 1'b1);
        end else begin
          got = held_values.pop_front();
          push_snapshot(got, fqpl_pkg::ST_OK, 1'b1);
        end
      end
      fqpl_pkg::OP_LIST: begin
        if (n == 0) begin
          push_snapshot('0, fqpl_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) push_snapshot(held_values[i], fqpl_pkg::ST_OK, i == n - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(logic [fqpl_pkg::OP_W-1:0] op,
                                   logic signed [fqpl_pkg::DATA_W-1:0] val,
                                   int ph, bit drain, bit hold);
    op_item_t it;
    it.operation = op;
    it.value     = val;
    it.phase     = ph;
    it.drain     = drain;
    it.hold      = hold;
    op_backlog.push_back(it);
    if (op == fqpl_pkg::OP_ENQ && gen_count < DEPTH) gen_count++;
    if (op == fqpl_pkg::OP_DEQ && gen_count > 0) gen_count--;
  endfunction

  function automatic logic signed [fqpl_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // fill and drain swings keep the queue moving between empty and full
  function automatic void add_random(int count, int ph, bit drain_first, int hold_at);
    logic [fqpl_pkg::OP_W-1:0] op;
    int r;
    int made;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (gen_count == DEPTH && $urandom_range(2) == 0) gen_filling = 1'b0;
      if (gen_count == 0 && $urandom_range(2) == 0) gen_filling = 1'b1;
      if (r < 64) op = gen_filling ? fqpl_pkg::OP_ENQ : fqpl_pkg::OP_DEQ;
      else if (r < 80) op = gen_filling ? fqpl_pkg::OP_DEQ : fqpl_pkg::OP_ENQ;
      else if (r < 94) op = fqpl_pkg::OP_LIST;
      else op = fqpl_pkg::OP_NONE;
      add_item(op, pick_value(), ph, drain_first && made == 0, made == hold_at);
      if (op != fqpl_pkg::OP_NONE) made++;
    end
  endfunction

  always @(posedge clk) begin : drive_proc
    op_item_t nxt;
    bit go;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_op(offered);
        items_taken++;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        go = 1'b0;
        if (op_backlog.size() > 0) begin
          nxt = op_backlog[0];
          if (!(nxt.drain && due_words.size() > 0) &&
              $urandom_range(99) >= sender_idle_pct(nxt.phase)) begin
            go = 1'b1;
            void'(op_backlog.pop_front());
            offered = nxt;
            if (nxt.hold) hold_requests <= hold_requests + 1;
            send_phase       <= nxt.phase;
            req_ch.operation <= nxt.operation;
            req_ch.value     <= nxt.value;
          end
        end
        req_ch.valid <= go;
      end
    end
  end

  always @(posedge clk) begin : check_proc
    snapshot_t got;
    snapshot_t want;
    logic nxt_ready;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.result_value = rsp_ch.result_value;
        got.status       = rsp_ch.status;
        got.entry_count  = rsp_ch.entry_count;
        got.queue_empty  = rsp_ch.queue_empty;
        got.front_value  = rsp_ch.front_value;
        got.rear_value   = rsp_ch.rear_value;
        got.last         = rsp_ch.last;
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word val=%0d st=%0d cnt=%0d", $realtime,
                     got.result_value, got.status, got.entry_count);
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  exp val=%0d st=%0d cnt=%0d empty=%0b front=%0d rear=%0d last=%0b",
                       want.result_value, want.status, want.entry_count, want.queue_empty,
                       want.front_value, want.rear_value, want.last);
              $display("  got val=%0d st=%0d cnt=%0d empty=%0b front=%0d rear=%0d last=%0b",
                       got.result_value, got.status, got.entry_count, got.queue_empty,
                       got.front_value, got.rear_value, got.last);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (holds_seen != hold_requests) begin
        holds_seen++;
        hold_left = HOLD_CYCLES - 1;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = $urandom_range(99) >= receiver_stall_pct(send_phase);
      end
      rsp_ch.ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.operation = fqpl_pkg::OP_NONE;
    req_ch.value     = '0;
    rsp_ch.ready     = 1'b0;
    items_taken      = 0;
    mismatches       = 0;
    send_phase       = 0;
    hold_requests    = 0;
    holds_seen       = 0;
    quiet_cycles     = 0;
    gen_count        = 0;
    gen_filling      = 1'b1;

    // empty queue cases and an unused code
    add_item(fqpl_pkg::OP_LIST, 32'sd5, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_DEQ, -32'sd1, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_NONE, -32'sd1, 0, 1'b0, 1'b0);
    // fill to full with extreme values first
    add_item(fqpl_pkg::OP_ENQ, 32'sh8000_0000, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_ENQ, 32'sh7fff_ffff, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_ENQ, '0, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_ENQ, -32'sd1, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_ENQ, 32'sh5555_5555, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_ENQ, 32'shaaaa_aaaa, 0, 1'b0, 1'b0);
    for (int i = 0; i < DEPTH - 6; i++) add_item(fqpl_pkg::OP_ENQ, $urandom, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_ENQ, 32'sd77, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_LIST, '0, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_NONE, '0, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_DEQ, '0, 0, 1'b0, 1'b0);
    add_item(fqpl_pkg::OP_DEQ, '0, 0, 1'b0, 1'b0);

    add_random(90, 0, 1'b0, 40);
    add_random(90, 1, 1'b1, -1);
    add_random(90, 2, 1'b1, -1);
    add_random(90, 3, 1'b0, 60);
    items_total = op_backlog.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (items_taken < items_total || due_words.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && due_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
hdl/fqpl_pkg.sv
hdl/fqpl_if.sv
hdl/fqpl_datapath.sv
hdl/fqpl_ctrl.sv
hdl/fifo_queue_with_peek_and_listing_core.sv
verif/fifo_queue_with_peek_and_listing_core_tb.sv
